/* hw/rtl/decimal_time_string_parser_core_macros.svh */
// ----------------------------------------------------------------------------
// decimal time string parser assertion macros
// shared concurrent assertion forms for the parser rtl
// ----------------------------------------------------------------------------
`ifndef DECIMAL_TIME_STRING_PARSER_CORE_MACROS_SVH
`define DECIMAL_TIME_STRING_PARSER_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define DTSP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define DTSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/dtsp_pkg.sv */
// ----------------------------------------------------------------------------
// dtsp_pkg
// widths, character codes, scale table and result type of the parser
// ----------------------------------------------------------------------------
package dtsp_pkg;

  // fixed field widths
  localparam int CHAR_W     = 8;
  localparam int SEC_OUT_W  = 64;
  localparam int NS_OUT_W   = 31;
  localparam int NS_MAG_W   = 30;
  localparam int CONS_W     = 16;
  localparam int EXP_W      = 4;

  // parameter defaults
  localparam int FRAC_DIGITS_DEF   = 9;
  localparam int SECONDS_WIDTH_DEF = 64;

  // nanosecond digit positions
  localparam logic [EXP_W-1:0] NS_DIGITS = EXP_W'(9);

  // character codes
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  // one result as it leaves the parser
  typedef struct packed {
    logic                        emit;
    logic                        status;
    logic signed [SEC_OUT_W-1:0] seconds;
    logic signed [NS_OUT_W-1:0]  nanoseconds;
    logic [CONS_W-1:0]           consumed;
  } dtsp_result_t;

  // powers of ten up to one second in nanoseconds
  function automatic logic [NS_MAG_W-1:0] pow10(input logic [EXP_W-1:0] e);
    logic [NS_MAG_W-1:0] v;
    case (e)
      4'd0:    v = 30'd1;
      4'd1:    v = 30'd10;
      4'd2:    v = 30'd100;
      4'd3:    v = 30'd1000;
      4'd4:    v = 30'd10000;
      4'd5:    v = 30'd100000;
      4'd6:    v = 30'd1000000;
      4'd7:    v = 30'd10000000;
      4'd8:    v = 30'd100000000;
      4'd9:    v = 30'd1000000000;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

/* hw/rtl/decimal_time_string_parser_core.sv */
// ----------------------------------------------------------------------------
// decimal_time_string_parser_core
// streaming decimal seconds string parser with registered in and out stages
// ----------------------------------------------------------------------------
// usage
//   input channel in_valid/in_ready carries one character per request in
//   in_char_in; a zero byte ends the string. leading white space and one sign
//   are taken, then seconds, an optional point and fraction digits.
//   the character that ends the number yields one result request on
//   out_valid/out_ready: out_status (1 = invalid), out_seconds,
//   out_nanoseconds (same sign) and out_consumed. further characters are
//   dropped until the zero byte, which rearms the parser.
// timing
//   one character per cycle sustained while no result waits on out_ready;
//   the whole per-character step (one times-ten add and range compare, or
//   the fraction scale multiply) sits between the input register and the
//   result register, so a result is registered from its ending character.
// reset and stall
//   synchronous active-low reset empties both stages and rearms the parser.
//   while a result waits on out_ready, one more character is held in the
//   input register; after that in_ready drops.
// ----------------------------------------------------------------------------
`include "decimal_time_string_parser_core_macros.svh"

module decimal_time_string_parser_core #(
  parameter int FRAC_DIGITS   = dtsp_pkg::FRAC_DIGITS_DEF,
  parameter int SECONDS_WIDTH = dtsp_pkg::SECONDS_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [dtsp_pkg::CHAR_W-1:0]           in_char_in,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_status,
  output logic signed [dtsp_pkg::SEC_OUT_W-1:0] out_seconds,
  output logic signed [dtsp_pkg::NS_OUT_W-1:0]  out_nanoseconds,
  output logic [dtsp_pkg::CONS_W-1:0]           out_consumed
);
  import dtsp_pkg::*;

  logic                        in_vld_r;
  logic [CHAR_W-1:0]           in_char_r;
  logic                        advance;
  dtsp_result_t                res;
  logic                        out_valid_r;
  logic                        out_status_r;
  logic signed [SEC_OUT_W-1:0] out_seconds_r;
  logic signed [NS_OUT_W-1:0]  out_ns_r;
  logic [CONS_W-1:0]           out_consumed_r;

  // held character moves on when the result slot is free or draining
  assign advance  = in_vld_r && (!out_valid_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_char_r <= in_char_in;
    end
  end

  // parse step
  dtsp_parser #(
    .FRAC_DIGITS   (FRAC_DIGITS),
    .SECONDS_WIDTH (SECONDS_WIDTH)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .char_in (in_char_r),
    .result  (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.emit) begin
      out_status_r   <= res.status;
      out_seconds_r  <= res.seconds;
      out_ns_r       <= res.nanoseconds;
      out_consumed_r <= res.consumed;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_seconds     = out_seconds_r;
  assign out_nanoseconds = out_ns_r;
  assign out_consumed    = out_consumed_r;

  // checks
  `DTSP_ASSERT_NEXT(a_emit_lands, clk, rst_n, res.emit, out_valid_r, "result request was lost")
  `DTSP_ASSERT_NEXT(a_held_char, clk, rst_n, in_vld_r && !advance,
                    in_vld_r && $stable(in_char_r), "held character was dropped")
  `DTSP_ASSERT_NOW(a_bad_zero, clk, rst_n, out_valid_r && out_status_r,
                   out_seconds_r == '0 && out_ns_r == '0 && out_consumed_r == '0,
                   "invalid result carries data")
  `DTSP_ASSERT_NOW(a_ok_count, clk, rst_n, out_valid_r && !out_status_r,
                   out_consumed_r != '0, "valid result consumed nothing")

endmodule

/* hw/rtl/dtsp_parser.sv */
// ----------------------------------------------------------------------------
// dtsp_parser
// per-character parse state, digit accumulation and result formatting
// ----------------------------------------------------------------------------
module dtsp_parser #(
  parameter int FRAC_DIGITS   = dtsp_pkg::FRAC_DIGITS_DEF,
  parameter int SECONDS_WIDTH = dtsp_pkg::SECONDS_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic [dtsp_pkg::CHAR_W-1:0] char_in,
  output dtsp_pkg::dtsp_result_t      result
);
  import dtsp_pkg::*;

  localparam int FRAC_W = $clog2(10**FRAC_DIGITS);
  localparam int FCNT_W = $clog2(FRAC_DIGITS + 2);
  localparam int SACC_W = SECONDS_WIDTH + 4;
  localparam logic [SECONDS_WIDTH-1:0] SEC_LIMIT = {1'b0, {(SECONDS_WIDTH-1){1'b1}}};
  localparam logic [FCNT_W-1:0] FCNT_MAX  = FCNT_W'(FRAC_DIGITS);
  localparam logic [FCNT_W-1:0] FCNT_OVER = FCNT_W'(FRAC_DIGITS + 1);

  typedef enum logic [2:0] {
    PH_SKIP,
    PH_SIGNED,
    PH_SECS,
    PH_LEAD_POINT,
    PH_SECS_POINT,
    PH_FRAC,
    PH_DONE
  } phase_t;

  phase_t                    phase_r, phase_nxt;
  logic                      neg_r, neg_nxt;
  logic [SECONDS_WIDTH-1:0]  sec_r, sec_nxt;
  logic                      sec_ovf_r, sec_ovf_nxt;
  logic [FRAC_W-1:0]         frac_r, frac_nxt;
  logic [FCNT_W-1:0]         fcnt_r, fcnt_nxt;
  logic [CONS_W-1:0]         ccnt_r, ccnt_nxt;

  logic                      is_dig, is_spc, is_sign, is_point;
  logic [3:0]                digit;
  logic [SACC_W-1:0]         sec_ten;
  logic                      sec_too_big;
  logic [FRAC_W+3:0]         frac_ten;
  logic                      emit_c, bad_c, clear_c;
  logic [CONS_W-1:0]         ccnt_inc;

  // character classes
  assign is_dig   = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
  assign is_spc   = (char_in == CH_SPACE) || ((char_in >= CH_TAB) && (char_in <= CH_CR));
  assign is_sign  = (char_in == CH_PLUS) || (char_in == CH_MINUS);
  assign is_point = (char_in == CH_POINT);
  assign digit    = char_in[3:0];

  // times ten plus digit, with the signed range check
  assign sec_ten     = ({4'b0, sec_r} << 3) + ({4'b0, sec_r} << 1) + SACC_W'(digit);
  assign sec_too_big = sec_ten > {4'b0, SEC_LIMIT};
  assign frac_ten    = ({4'b0, frac_r} << 3) + ({4'b0, frac_r} << 1) + (FRAC_W + 4)'(digit);

  // saturating consumed count
  assign ccnt_inc = (ccnt_r == {CONS_W{1'b1}}) ? ccnt_r : ccnt_r + CONS_W'(1);

  // next state
  always_comb begin
    phase_nxt   = phase_r;
    neg_nxt     = neg_r;
    sec_nxt     = sec_r;
    sec_ovf_nxt = sec_ovf_r;
    frac_nxt    = frac_r;
    fcnt_nxt    = fcnt_r;
    ccnt_nxt    = ccnt_r;
    emit_c      = 1'b0;
    bad_c       = 1'b0;
    clear_c     = 1'b0;

    case (phase_r)
      PH_SKIP, PH_SIGNED: begin
        if ((phase_r == PH_SKIP) && is_spc) begin
          ccnt_nxt = ccnt_inc;
        end else if ((phase_r == PH_SKIP) && is_sign) begin
          neg_nxt   = (char_in == CH_MINUS);
          ccnt_nxt  = ccnt_inc;
          phase_nxt = PH_SIGNED;
        end else if (is_dig) begin
          ccnt_nxt  = ccnt_inc;
          phase_nxt = PH_SECS;
          if (!sec_ovf_r) begin
            if (sec_too_big) sec_ovf_nxt = 1'b1;
            else             sec_nxt     = sec_ten[SECONDS_WIDTH-1:0];
          end
        end else if (is_point) begin
          ccnt_nxt  = ccnt_inc;
          phase_nxt = PH_LEAD_POINT;
        end else begin
          emit_c = 1'b1;
          bad_c  = 1'b1;
        end
      end
      PH_SECS: begin
        if (is_dig) begin
          ccnt_nxt = ccnt_inc;
          if (!sec_ovf_r) begin
            if (sec_too_big) sec_ovf_nxt = 1'b1;
            else             sec_nxt     = sec_ten[SECONDS_WIDTH-1:0];
          end
        end else if (is_point) begin
          ccnt_nxt  = ccnt_inc;
          phase_nxt = PH_SECS_POINT;
        end else begin
          emit_c = 1'b1;
          bad_c  = sec_ovf_r;
        end
      end
      PH_LEAD_POINT, PH_SECS_POINT, PH_FRAC: begin
        if (is_dig) begin
          ccnt_nxt  = ccnt_inc;
          phase_nxt = PH_FRAC;
          if (fcnt_r < FCNT_MAX) begin
            frac_nxt = frac_ten[FRAC_W-1:0];
            fcnt_nxt = fcnt_r + FCNT_W'(1);
          end else begin
            fcnt_nxt = FCNT_OVER;
          end
        end else begin
          emit_c = 1'b1;
          if (phase_r == PH_LEAD_POINT) bad_c = 1'b1;
          else                          bad_c = sec_ovf_r || (fcnt_r > FCNT_MAX);
        end
      end
      PH_DONE: begin
        clear_c = (char_in == CH_NUL);
      end
      default: begin
        clear_c = 1'b1;
      end
    endcase

    // a result parks the parser until the string ends
    if (emit_c) begin
      phase_nxt = PH_DONE;
      clear_c   = (char_in == CH_NUL);
    end
  end

  // parse state
  always_ff @(posedge clk) begin
    if (!rst_n || (step && clear_c)) begin
      phase_r   <= PH_SKIP;
      neg_r     <= 1'b0;
      sec_r     <= '0;
      sec_ovf_r <= 1'b0;
      frac_r    <= '0;
      fcnt_r    <= '0;
      ccnt_r    <= '0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      neg_r     <= neg_nxt;
      sec_r     <= sec_nxt;
      sec_ovf_r <= sec_ovf_nxt;
      frac_r    <= frac_nxt;
      fcnt_r    <= fcnt_nxt;
      ccnt_r    <= ccnt_nxt;
    end
  end

  // result formatting from the state before the ending character
  logic [NS_MAG_W-1:0]  ns_mag;
  logic [NS_OUT_W-1:0]  ns_ext;
  logic [SEC_OUT_W-1:0] sec_ext;
  logic                 frac_used;

  assign frac_used = (fcnt_r != '0) && (fcnt_r <= FCNT_MAX);
  assign ns_mag    = frac_used ?
                     NS_MAG_W'(frac_r) * pow10(NS_DIGITS - EXP_W'(fcnt_r)) : '0;
  assign ns_ext    = {1'b0, ns_mag};
  assign sec_ext   = SEC_OUT_W'(sec_r);

  always_comb begin
    result.emit = step && emit_c;
    if (bad_c) begin
      result.status      = 1'b1;
      result.seconds     = '0;
      result.nanoseconds = '0;
      result.consumed    = '0;
    end else begin
      result.status      = 1'b0;
      result.seconds     = neg_r ? -sec_ext : sec_ext;
      result.nanoseconds = neg_r ? -ns_ext : ns_ext;
      result.consumed    = ccnt_r;
    end
  end

endmodule
